FILE: sv/rgb565_pair_to_ycbycr_assert.svh
// ----------------------------------------------------------------------------
// rgb565_pair_to_ycbycr assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RGB565_PAIR_TO_YCBYCR_ASSERT_SVH
`define RGB565_PAIR_TO_YCBYCR_ASSERT_SVH

// same-cycle implication
`define R2Y_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define R2Y_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/r2ycc_pkg.sv
// ----------------------------------------------------------------------------
// r2ycc_pkg
// Types, BT.601 fixed-point coefficients and conversion functions.
// ----------------------------------------------------------------------------
`default_nettype none

package r2ycc_pkg;

  typedef logic [15:0] px565_t;

  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] luma_first;
  } ycc_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb8_t;

  localparam logic [15:0] KYR = 16'd19595;
  localparam logic [15:0] KYG = 16'd38469;
  localparam logic [15:0] KYB = 16'd7471;

  localparam logic signed [16:0] KUR = -17'sd11075;
  localparam logic signed [16:0] KUG = -17'sd21692;
  localparam logic signed [16:0] KUB = 17'sd32768;
  localparam logic signed [16:0] KVR = 17'sd32768;
  localparam logic signed [16:0] KVG = -17'sd27459;
  localparam logic signed [16:0] KVB = -17'sd5308;

  localparam logic [7:0] LumaLo   = 8'd16;
  localparam logic [7:0] LumaHi   = 8'd235;
  localparam logic [7:0] ChromaLo = 8'd16;
  localparam logic [7:0] ChromaHi = 8'd240;
  localparam logic [7:0] ChromaMid = 8'd128;

  localparam ycc_t BlackYcc = 32'h8000_8000;

  function automatic rgb8_t widen565(px565_t p);
    rgb8_t c;
    c.r = {p[15:11], p[15:13]};
    c.g = {p[10:5], p[10:9]};
    c.b = {p[4:0], p[4:2]};
    return c;
  endfunction

  function automatic logic [7:0] avg8(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [7:0] luma_of(rgb8_t c);
    logic [23:0] s;
    logic [8:0]  q;
    s = ({8'b0, KYR} * {16'b0, c.r}) + ({8'b0, KYG} * {16'b0, c.g})
      + ({8'b0, KYB} * {16'b0, c.b});
    q = {1'b0, s[23:16]} + {1'b0, LumaLo};
    if (q > {1'b0, LumaHi}) begin
      return LumaHi;
    end
    return q[7:0];
  endfunction

  function automatic logic [7:0] chroma_of(rgb8_t c, logic signed [16:0] kr,
                                           logic signed [16:0] kg,
                                           logic signed [16:0] kb);
    logic signed [26:0] s;
    logic signed [10:0] q;
    s = (27'(kr) * $signed({19'b0, c.r})) + (27'(kg) * $signed({19'b0, c.g}))
      + (27'(kb) * $signed({19'b0, c.b}));
    q = 11'(s >>> 16) + $signed({3'b000, ChromaMid});
    if (q < $signed({3'b000, ChromaLo})) begin
      return ChromaLo;
    end
    if (q > $signed({3'b000, ChromaHi})) begin
      return ChromaHi;
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/r2ycc_conv.sv
// ----------------------------------------------------------------------------
// r2ycc_conv
// Combinational RGB565 pair to YCbYCr conversion, BT.601 fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module r2ycc_conv (
  input  r2ycc_pkg::px565_t first_pixel_i,
  input  r2ycc_pkg::px565_t second_pixel_i,
  output r2ycc_pkg::ycc_t   ycc_o
);
  import r2ycc_pkg::*;

  rgb8_t c1;
  rgb8_t c2;
  rgb8_t cavg;
  ycc_t  ycc;

  always_comb begin
    c1     = widen565(first_pixel_i);
    c2     = widen565(second_pixel_i);
    cavg.r = avg8(c1.r, c2.r);
    cavg.g = avg8(c1.g, c2.g);
    cavg.b = avg8(c1.b, c2.b);

    ycc.luma_first  = luma_of(c1);
    ycc.luma_second = luma_of(c2);
    ycc.chroma_blue = chroma_of(cavg, KUR, KUG, KUB);
    ycc.chroma_red  = chroma_of(cavg, KVR, KVG, KVB);

    // both pixels black: force luma to zero
    if ((first_pixel_i | second_pixel_i) == '0) begin
      ycc = BlackYcc;
    end
  end

  assign ycc_o = ycc;

endmodule

`default_nettype wire

FILE: sv/rgb565_pair_to_ycbycr.sv
// ----------------------------------------------------------------------------
// rgb565_pair_to_ycbycr
// RGB565 pixel pair to YCbYCr 4:2:2 stream converter, BT.601 coefficients.
// ----------------------------------------------------------------------------
// Accepts one pixel pair per clock and returns one YCbYCr word per pair, in
// order. On its way from input beat to output beat the pair is
// captured in an input register, converted by one pass of constant
// multiply-add and clamp logic, and held in the result register until taken.
// Throughput is set by that single conversion stage: one pair every cycle
// while the output side keeps tready high. A stalled output fills both
// registers, after which s_axis_tready drops until the result moves on.
`default_nettype none

module rgb565_pair_to_ycbycr (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // first_pixel[15:0], second_pixel[31:16]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata    // luma_first[7:0], chroma_blue[15:8],
                                           // luma_second[23:16], chroma_red[31:24]
);
  import r2ycc_pkg::*;

  logic    s0_valid_q;
  px565_t  s0_first_q;
  px565_t  s0_second_q;
  logic    out_valid_q;
  ycc_t    out_q;
  ycc_t    ycc;
  logic    out_load;
  logic    s0_load;

  assign out_load      = !out_valid_q || m_axis_tready;
  assign s0_load       = !s0_valid_q || out_load;
  assign s_axis_tready = s0_load;

  r2ycc_conv u_conv (
    .first_pixel_i  (s0_first_q),
    .second_pixel_i (s0_second_q),
    .ycc_o          (ycc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_load) begin
        s0_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_load && s_axis_tvalid) begin
      s0_first_q  <= s_axis_tdata[15:0];
      s0_second_q <= s_axis_tdata[31:16];
    end
    if (out_load && s0_valid_q) begin
      out_q <= ycc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`include "rgb565_pair_to_ycbycr_assert.svh"

  `R2Y_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready,
    s0_valid_q && out_valid_q && !m_axis_tready, "input stalled while a stage is free")
  `R2Y_ASSERT_NXT(a_stage_advances, s0_valid_q && out_load,
    m_axis_tvalid, "converted pair lost between stages")
  `R2Y_ASSERT_IMP(a_result_range, m_axis_tvalid,
    out_q.luma_first <= LumaHi && out_q.luma_second <= LumaHi &&
    out_q.chroma_blue >= ChromaLo && out_q.chroma_blue <= ChromaHi &&
    out_q.chroma_red >= ChromaLo && out_q.chroma_red <= ChromaHi,
    "result field out of range")
  `R2Y_ASSERT_IMP(a_black_pair, m_axis_tvalid && out_q.luma_first == '0,
    out_q == BlackYcc, "zero luma outside the black-pair case")

endmodule

`default_nettype wire

FILE: verif/tb_rgb565_pair_to_ycbycr.sv
// ----------------------------------------------------------------------------
// tb_rgb565_pair_to_ycbycr
// Stream testbench for the RGB565 pair to YCbYCr 4:2:2 converter. Pixel pairs
// go in as beats and are predicted in a scoreboard; each output beat is
// checked field by field against the oldest prediction. Both stream sides idle
// at random, with one long output hold-off that backs the converter up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb565_pair_to_ycbycr;
  timeunit 1ns;
  timeprecision 1ps;

  import r2ycc_pkg::px565_t;
  import r2ycc_pkg::ycc_t;

  localparam int          Y_FLOOR      = 16;
  localparam int          Y_CEIL       = 235;
  localparam int          C_FLOOR      = 16;
  localparam int          C_CEIL       = 240;
  localparam int          C_OFFSET     = 128;
  localparam int          CY_R         = 19595;
  localparam int          CY_G         = 38469;
  localparam int          CY_B         = 7471;
  localparam int          CB_R         = -11075;
  localparam int          CB_G         = -21692;
  localparam int          CB_B         = 32768;
  localparam int          CR_R         = 32768;
  localparam int          CR_G         = -27459;
  localparam int          CR_B         = -5308;
  localparam int unsigned RANDOM_PAIRS = 1080;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_OFF_AT  = 300;
  localparam int unsigned HOLD_OFF_LEN = 80;

  class ycc_scoreboard;
    ycc_t        pending[$];
    int unsigned faults;

    static function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function void expand(px565_t p, output int r, output int g, output int b);
      r = (int'(p[15:11]) << 3) | (int'(p[15:11]) >> 2);
      g = (int'(p[10:5]) << 2) | (int'(p[10:5]) >> 4);
      b = (int'(p[4:0]) << 3) | (int'(p[4:0]) >> 2);
    endfunction

    static function ycc_t pair_to_ycc(px565_t a, px565_t b);
      int   ra, ga, ba, rb, gb, bb, r, g, bl;
      ycc_t w;
      if ((a | b) == 16'h0000) begin
        w.luma_first  = 8'd0;
        w.chroma_blue = 8'(C_OFFSET);
        w.luma_second = 8'd0;
        w.chroma_red  = 8'(C_OFFSET);
        return w;
      end
      expand(a, ra, ga, ba);
      expand(b, rb, gb, bb);
      w.luma_first  = 8'(clamp(((CY_R * ra + CY_G * ga + CY_B * ba) >>> 16) + Y_FLOOR,
                               Y_FLOOR, Y_CEIL));
      w.luma_second = 8'(clamp(((CY_R * rb + CY_G * gb + CY_B * bb) >>> 16) + Y_FLOOR,
                               Y_FLOOR, Y_CEIL));
      r  = (ra + rb) >> 1;
      g  = (ga + gb) >> 1;
      bl = (ba + bb) >> 1;
      w.chroma_blue = 8'(clamp(((CB_R * r + CB_G * g + CB_B * bl) >>> 16) + C_OFFSET,
                               C_FLOOR, C_CEIL));
      w.chroma_red  = 8'(clamp(((CR_R * r + CR_G * g + CR_B * bl) >>> 16) + C_OFFSET,
                               C_FLOOR, C_CEIL));
      return w;
    endfunction

    function void note_pair(px565_t a, px565_t b);
      pending.push_back(pair_to_ycc(a, b));
    endfunction

    function void check_word(ycc_t got);
      ycc_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN) $display("unexpected output beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.luma_first !== want.luma_first || got.chroma_blue !== want.chroma_blue ||
          got.luma_second !== want.luma_second || got.chroma_red !== want.chroma_red) begin
        faults++;
        if (faults <= MAX_SHOWN)
          $display("mismatch Y1/Cb/Y2/Cr: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   want.luma_first, want.chroma_blue, want.luma_second, want.chroma_red,
                   got.luma_first, got.chroma_blue, got.luma_second, got.chroma_red);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  ycc_scoreboard sb = new();
  int unsigned   pairs_sent;

  rgb565_pair_to_ycbycr DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [5:0] pick_field(int unsigned bits);
    logic [5:0] all_ones;
    all_ones = 6'((1 << bits) - 1);
    case ($urandom_range(0, 2))
      0: return 6'd0;
      1: return all_ones;
      default: return 6'($urandom) & all_ones;
    endcase
  endfunction

  function automatic px565_t extreme_px();
    px565_t p;
    p[15:11] = 5'(pick_field(5));
    p[10:5]  = pick_field(6);
    p[4:0]   = 5'(pick_field(5));
    return p;
  endfunction

  task automatic send_pair(px565_t a, px565_t b);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(a, b);
    pairs_sent++;
    gap = ((pairs_sent / 200) % 3 == 2) ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_pair();
    px565_t a, b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    a = px565_t'($urandom);
    b = px565_t'($urandom);
    if (pick < 15) begin
      b = a;
    end else if (pick < 20) begin
      a = '0;
      b = '0;
    end else if (pick < 27) begin
      if ($urandom_range(0, 1)) a = '0;
      else b = '0;
    end else if (pick < 50) begin
      a = extreme_px();
      b = ($urandom_range(0, 2) == 0) ? a : extreme_px();
    end else if (pick < 60) begin
      b = a ^ px565_t'(1 << $urandom_range(0, 15));
    end
    send_pair(a, b);
  endtask

  initial begin : rx_ready_gen
    int unsigned cyc;
    int unsigned low_left;
    cyc      = 0;
    low_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == HOLD_OFF_AT)
        low_left = HOLD_OFF_LEN;
      else if (low_left == 0 && (cyc / 500) % 4 != 3 && $urandom_range(0, 99) < 25)
        low_left = idle_len();
      if (low_left != 0) begin
        m_axis_tready <= 1'b0;
        low_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(ycc_t'(m_axis_tdata));
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    pairs_sent = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h0000, 16'h0001);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hF800, 16'hF800);
    send_pair(16'h07E0, 16'h07E0);
    send_pair(16'h001F, 16'h001F);
    send_pair(16'hFFE0, 16'hFFE0);
    send_pair(16'hF81F, 16'hF81F);
    send_pair(16'h07FF, 16'h07FF);
    send_pair(16'hF800, 16'h001F);
    send_pair(16'h0821, 16'h0000);
    send_pair(16'h8410, 16'h8410);
    send_pair(16'h1234, 16'h1234);
    send_pair(16'h0001, 16'h0002);
    send_pair(16'hFFFE, 16'hFFFF);
    send_pair(16'h0020, 16'h0800);
    send_pair(16'h5555, 16'hAAAA);
    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) send_random_pair();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.faults);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/r2ycc_pkg.sv
sv/r2ycc_conv.sv
sv/rgb565_pair_to_ycbycr.sv
verif/tb_rgb565_pair_to_ycbycr.sv
